>>> rtl/core/arpic_pkg.sv
// Shared types and constants for the ARP / ICMP echo receive classifier.
// Used by arpic_cfg_regs, arpic_parser and arp_icmp_frame_classifier_unit.
// No dependencies.
`timescale 1ns / 1ps

package arpic_pkg;

    // Frame length limit default (byte counter saturates here)
    localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 2047;

    // Ethertypes
    localparam logic [15:0] KIND_ARP  = 16'h0806;
    localparam logic [15:0] KIND_IPV4 = 16'h0800;

    // Register reset values
    localparam logic [31:0] LOCAL_IP_RESET   = 32'h0000_0000;
    localparam logic [31:0] TARGET_IP_RESET  = 32'h0000_0000;
    localparam logic [15:0] EXP_SEQ_RESET    = 16'h0001;
    localparam logic [15:0] ECHO_ID_RESET    = 16'h1337;

    // Field helpers
    localparam logic [3:0]  NIBBLE_MASK      = 4'hF;
    localparam logic [3:0]  IPV4_VERSION     = 4'd4;
    localparam logic [3:0]  MIN_HDR_WORDS    = 4'd5;
    localparam logic [7:0]  PROTO_ICMP       = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REPLY  = 8'd0;
    localparam logic [7:0]  ICMP_CODE_ZERO   = 8'd0;
    localparam logic [15:0] ARP_OP_REQUEST   = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY     = 16'd2;

    // Byte offsets within the frame
    localparam int unsigned OFS_KIND_HI      = 12;
    localparam int unsigned OFS_KIND_LO      = 13;
    localparam int unsigned OFS_ARP_OP_HI    = 20;
    localparam int unsigned OFS_ARP_OP_LO    = 21;
    localparam int unsigned OFS_ARP_SHA_FIRST = 22;
    localparam int unsigned OFS_ARP_SHA_LAST = 27;
    localparam int unsigned OFS_ARP_SPA_FIRST = 28;
    localparam int unsigned OFS_ARP_SPA_LAST = 31;
    localparam int unsigned OFS_ARP_TPA_FIRST = 38;
    localparam int unsigned OFS_ARP_TPA_LAST = 41;
    localparam int unsigned OFS_IP_VER_IHL   = 14;
    localparam int unsigned OFS_IP_PROTO     = 23;
    localparam int unsigned OFS_IP_SRC_FIRST = 26;
    localparam int unsigned OFS_IP_SRC_LAST  = 29;
    localparam int unsigned OFS_IP_DST_FIRST = 30;
    localparam int unsigned OFS_IP_DST_LAST  = 33;

    // Length rules
    localparam int unsigned ARP_MIN_BYTES    = 42;
    localparam int unsigned ETH_HDR_BYTES    = 14;
    localparam int unsigned ECHO_BYTES       = 40;
    localparam int unsigned ICMP_HDR_BYTES   = 8;

    // Offsets inside the ICMP header
    localparam logic [2:0] ICMP_OFS_TYPE     = 3'd0;
    localparam logic [2:0] ICMP_OFS_CODE     = 3'd1;
    localparam logic [2:0] ICMP_OFS_ID_HI    = 3'd4;
    localparam logic [2:0] ICMP_OFS_ID_LO    = 3'd5;
    localparam logic [2:0] ICMP_OFS_SEQ_HI   = 3'd6;
    localparam logic [2:0] ICMP_OFS_SEQ_LO   = 3'd7;

    // Stream widths
    localparam int unsigned M_TDATA_W        = 88;
    localparam int unsigned CFG_DATA_W       = 32;

    typedef enum logic [1:0] {
        CFG_LOCAL_IP      = 2'd0,
        CFG_TARGET_IP     = 2'd1,
        CFG_EXPECTED_SEQ  = 2'd2,
        CFG_ECHO_ID       = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        VERDICT_NONE        = 2'd0,
        VERDICT_ARP_REQUEST = 2'd1,
        VERDICT_ARP_REPLY   = 2'd2,
        VERDICT_ECHO_REPLY  = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [31:0] target_ip;
        logic [15:0] expected_sequence;
        logic [15:0] echo_identifier;
    } t_cfg;

    typedef struct packed {
        t_verdict    verdict;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
    } t_result;

endpackage

>>> rtl/core/arp_icmp_frame_classifier_unit.sv
// Top level of the ARP / ICMP echo receive classifier: input register,
// output register and handshake. Depends on arpic_pkg, arpic_cfg_regs, arpic_parser.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: one Ethernet frame byte per request, starting at the
//   destination MAC; tlast marks the final byte of a frame.
//   Master stream: one request per frame, issued for its last byte, carrying
//   the verdict and, for ARP verdicts, the sender MAC and IP (zero otherwise).
//   Config port: write enable, register index, 32-bit data; write only while
//   no frame is in flight.
// Timing: an accepted byte is held in the input register and parsed from there;
//   for the last byte the verdict is written into the result register, from
//   which the master side takes it.
// Throughput: one byte per cycle unless stalled as below. The parse of each byte
//   is one pass of compare/shift logic between the input register and the
//   state/result registers, so only the stall below limits the rate.
// Stall: the block only holds back when a last byte waits in the input
//   register while the result register is full and not taken; tready then
//   drops until the master side accepts the pending result.
// Reset (synchronous, active low): clears the pipeline, the frame state and
//   restores the configuration registers to their reset values.

module arp_icmp_frame_classifier_unit
    import arpic_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,   // last_byte
    // Master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [1:0] verdict, [49:2] peer_mac,
                                                    // [81:50] peer_ip, [87:82] zero
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg       w_cfg;
    t_result    w_result;
    logic       w_advance;
    logic       w_step;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    arpic_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_index'(i_cfg_index)),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    arpic_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // The held byte moves on unless it needs the result slot and the slot is blocked
    assign w_advance       = !(r_in_last && r_out_valid && !i_m_axis_tready);
    assign w_step          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out.peer_ip, r_out.peer_mac, r_out.verdict};

    // Only ARP verdicts carry peer addresses
    a_peer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict != VERDICT_ARP_REQUEST
            && r_out.verdict != VERDICT_ARP_REPLY)
        |-> (r_out.peer_mac == '0 && r_out.peer_ip == '0))
        else $error("peer fields set without an ARP verdict");

    // A last byte blocked by a full result slot must stall the slave side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !i_m_axis_tready)
        |-> (!o_s_axis_tready && !w_step))
        else $error("blocked last byte not stalling input");

    // A non-last byte never produces a result
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !r_in_last && (!r_out_valid || i_m_axis_tready))
        |=> !r_out_valid)
        else $error("result issued for a non-last byte");

    // Reset empties both pipeline registers
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule

>>> rtl/core/arpic_cfg_regs.sv
// Configuration register file: local/target IP, echo identifier and sequence.
// Depends on arpic_pkg.
`timescale 1ns / 1ps

module arpic_cfg_regs
    import arpic_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOCAL_IP:     n_cfg.local_ip          = i_cfg_wdata;
                CFG_TARGET_IP:    n_cfg.target_ip         = i_cfg_wdata;
                CFG_EXPECTED_SEQ: n_cfg.expected_sequence = i_cfg_wdata[15:0];
                CFG_ECHO_ID:      n_cfg.echo_identifier   = i_cfg_wdata[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_ip          <= LOCAL_IP_RESET;
            r_cfg.target_ip         <= TARGET_IP_RESET;
            r_cfg.expected_sequence <= EXP_SEQ_RESET;
            r_cfg.echo_identifier   <= ECHO_ID_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/arpic_parser.sv
// Per-frame field capture and verdict logic; one byte per i_step strobe.
// Depends on arpic_pkg.
`timescale 1ns / 1ps

module arpic_parser
    import arpic_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    // Frame state
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_kind;
    logic [15:0]      r_arp_op;
    logic [47:0]      r_sha;
    logic [31:0]      r_spa;
    logic [31:0]      r_tpa;
    logic [3:0]       r_hw;
    logic             r_ip_ok;
    logic             r_echo_ok;

    // State after this byte, before the end-of-frame clear
    logic [CNT_W-1:0] u_cnt;
    logic [15:0]      u_kind;
    logic [15:0]      u_arp_op;
    logic [47:0]      u_sha;
    logic [31:0]      u_spa;
    logic [31:0]      u_tpa;
    logic [3:0]       u_hw;
    logic             u_ip_ok;
    logic             u_echo_ok;

    logic [CNT_W-1:0] idx;
    logic [6:0]       icmp_ofs;
    logic [6:0]       icmp_end;
    logic [2:0]       icmp_rel;
    logic             in_icmp;
    logic [6:0]       echo_min;
    t_result          result;

    assign idx      = r_cnt;
    assign icmp_ofs = 7'(ETH_HDR_BYTES) + 7'({r_hw, 2'b00});
    assign icmp_end = icmp_ofs + 7'(ICMP_HDR_BYTES);
    assign icmp_rel = 3'(idx - CNT_W'(icmp_ofs));
    assign in_icmp  = (r_hw >= MIN_HDR_WORDS) && (idx >= CNT_W'(icmp_ofs))
                      && (idx < CNT_W'(icmp_end));

    // Field capture for one byte
    always_comb begin
        u_kind    = r_kind;
        u_arp_op  = r_arp_op;
        u_sha     = r_sha;
        u_spa     = r_spa;
        u_tpa     = r_tpa;
        u_hw      = r_hw;
        u_ip_ok   = r_ip_ok;
        u_echo_ok = r_echo_ok;

        if (idx == CNT_W'(OFS_KIND_HI) || idx == CNT_W'(OFS_KIND_LO)) begin
            u_kind = {r_kind[7:0], i_byte};
        end else if (r_kind == KIND_ARP) begin
            if (idx == CNT_W'(OFS_ARP_OP_HI) || idx == CNT_W'(OFS_ARP_OP_LO)) begin
                u_arp_op = {r_arp_op[7:0], i_byte};
            end else if (idx >= CNT_W'(OFS_ARP_SHA_FIRST)
                         && idx <= CNT_W'(OFS_ARP_SHA_LAST)) begin
                u_sha = {r_sha[39:0], i_byte};
            end else if (idx >= CNT_W'(OFS_ARP_SPA_FIRST)
                         && idx <= CNT_W'(OFS_ARP_SPA_LAST)) begin
                u_spa = {r_spa[23:0], i_byte};
            end else if (idx >= CNT_W'(OFS_ARP_TPA_FIRST)
                         && idx <= CNT_W'(OFS_ARP_TPA_LAST)) begin
                u_tpa = {r_tpa[23:0], i_byte};
            end
        end else if (r_kind == KIND_IPV4) begin
            if (idx == CNT_W'(OFS_IP_VER_IHL)) begin
                u_hw    = i_byte[3:0] & NIBBLE_MASK;
                u_ip_ok = (i_byte[7:4] == IPV4_VERSION)
                          && ((i_byte[3:0] & NIBBLE_MASK) >= MIN_HDR_WORDS);
            end else if (idx == CNT_W'(OFS_IP_PROTO)) begin
                u_ip_ok = r_ip_ok && (i_byte == PROTO_ICMP);
            end else if (idx >= CNT_W'(OFS_IP_SRC_FIRST)
                         && idx <= CNT_W'(OFS_IP_SRC_LAST)) begin
                u_spa = {r_spa[23:0], i_byte};
            end else if (idx >= CNT_W'(OFS_IP_DST_FIRST)
                         && idx <= CNT_W'(OFS_IP_DST_LAST)) begin
                u_tpa = {r_tpa[23:0], i_byte};
            end else if (in_icmp) begin
                case (icmp_rel)
                    ICMP_OFS_TYPE:   u_echo_ok = (i_byte == ICMP_ECHO_REPLY);
                    ICMP_OFS_CODE:   u_echo_ok = r_echo_ok && (i_byte == ICMP_CODE_ZERO);
                    ICMP_OFS_ID_HI:  u_echo_ok = r_echo_ok
                                     && (i_byte == i_cfg.echo_identifier[15:8]);
                    ICMP_OFS_ID_LO:  u_echo_ok = r_echo_ok
                                     && (i_byte == i_cfg.echo_identifier[7:0]);
                    ICMP_OFS_SEQ_HI: u_echo_ok = r_echo_ok
                                     && (i_byte == i_cfg.expected_sequence[15:8]);
                    ICMP_OFS_SEQ_LO: u_echo_ok = r_echo_ok
                                     && (i_byte == i_cfg.expected_sequence[7:0]);
                    default:         u_echo_ok = r_echo_ok;
                endcase
            end
        end
    end

    // Saturating byte counter
    assign u_cnt = (r_cnt < CNT_W'(MAX_FRAME_BYTES)) ? r_cnt + 1'b1 : r_cnt;

    // Verdict on the updated state
    assign echo_min = 7'(ETH_HDR_BYTES + ECHO_BYTES) + 7'({u_hw, 2'b00});

    always_comb begin
        result = '{verdict: VERDICT_NONE, peer_mac: '0, peer_ip: '0};
        if (u_kind == KIND_ARP && u_cnt >= CNT_W'(ARP_MIN_BYTES)) begin
            if (u_arp_op == ARP_OP_REQUEST && u_tpa == i_cfg.local_ip) begin
                result.verdict = VERDICT_ARP_REQUEST;
            end else if (u_arp_op == ARP_OP_REPLY && u_spa == i_cfg.target_ip
                         && u_tpa == i_cfg.local_ip) begin
                result.verdict = VERDICT_ARP_REPLY;
            end
            if (result.verdict != VERDICT_NONE) begin
                result.peer_mac = u_sha;
                result.peer_ip  = u_spa;
            end
        end else if (u_kind == KIND_IPV4 && u_ip_ok && u_echo_ok
                     && u_spa == i_cfg.target_ip && u_tpa == i_cfg.local_ip
                     && u_cnt >= CNT_W'(echo_min)) begin
            result.verdict = VERDICT_ECHO_REPLY;
        end
    end

    assign o_result = result;

    // State update; the last byte clears everything for the next frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_cnt     <= '0;
            r_kind    <= '0;
            r_arp_op  <= '0;
            r_sha     <= '0;
            r_spa     <= '0;
            r_tpa     <= '0;
            r_hw      <= '0;
            r_ip_ok   <= 1'b0;
            r_echo_ok <= 1'b0;
        end else if (i_step) begin
            r_cnt     <= u_cnt;
            r_kind    <= u_kind;
            r_arp_op  <= u_arp_op;
            r_sha     <= u_sha;
            r_spa     <= u_spa;
            r_tpa     <= u_tpa;
            r_hw      <= u_hw;
            r_ip_ok   <= u_ip_ok;
            r_echo_ok <= u_echo_ok;
        end
    end

endmodule

>>> verif/arp_icmp_frame_classifier_unit_tb.sv
// Self-checking testbench for arp_icmp_frame_classifier_unit: drives whole Ethernet
// frames byte by byte and checks each verdict against an in-bench frame classifier or a typed row.
// Depends on arpic_pkg and the RTL of arp_icmp_frame_classifier_unit.
`timescale 1ns / 1ps

module arp_icmp_frame_classifier_unit_tb;
    import arpic_pkg::*;

    localparam int unsigned FRAME_CAP   = DEFAULT_MAX_FRAME_BYTES;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef enum logic [1:0] {
        FR_ARP,
        FR_IPV4,
        FR_OTHER
    } t_frame_kind;

    // Everything needed to lay out one frame; IPv4 frames reuse spa/tpa as src/dst
    typedef struct {
        t_frame_kind kind;
        int unsigned len;
        logic [15:0] ether;
        logic [15:0] arp_op;
        logic [47:0] sha;
        logic [31:0] spa;
        logic [31:0] tpa;
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] ident;
        logic [15:0] seq;
    } t_frame;

    typedef enum logic [4:0] {
        SC_ONE_BYTE,
        SC_ARP_REQUEST,
        SC_ARP_MIN,
        SC_ARP_SHORT,
        SC_ARP_REPLY,
        SC_ARP_BAD_SENDER,
        SC_ARP_OTHER_TPA,
        SC_ARP_BAD_OP,
        SC_ECHO,
        SC_ECHO_SHORT,
        SC_ECHO_OPTIONS,
        SC_ECHO_IHL_LOW,
        SC_ECHO_IHL_ZERO,
        SC_ECHO_VERSION,
        SC_ECHO_PROTO,
        SC_ECHO_TYPE,
        SC_ECHO_CODE,
        SC_ECHO_BAD_ID,
        SC_ECHO_BAD_SEQ,
        SC_ECHO_BAD_DST,
        SC_OTHER_KIND
    } t_scenario;

    typedef struct {
        t_scenario scenario;
        bit        typed;
        t_verdict  verdict;
    } t_directed_row;

    // Directed frames, all under reset configuration; typed rows carry the verdict
    t_directed_row directed_rows[21] = '{
        '{SC_ONE_BYTE,       1'b1, VERDICT_NONE},
        '{SC_ARP_REQUEST,    1'b1, VERDICT_ARP_REQUEST},
        '{SC_ARP_MIN,        1'b1, VERDICT_ARP_REQUEST},
        '{SC_ARP_SHORT,      1'b1, VERDICT_NONE},
        '{SC_ARP_REPLY,      1'b1, VERDICT_ARP_REPLY},
        '{SC_ARP_BAD_SENDER, 1'b1, VERDICT_NONE},
        '{SC_ARP_OTHER_TPA,  1'b1, VERDICT_NONE},
        '{SC_ARP_BAD_OP,     1'b1, VERDICT_NONE},
        '{SC_ECHO,           1'b1, VERDICT_ECHO_REPLY},
        '{SC_ECHO_SHORT,     1'b1, VERDICT_NONE},
        '{SC_ECHO_OPTIONS,   1'b0, VERDICT_NONE},
        '{SC_ECHO_IHL_LOW,   1'b1, VERDICT_NONE},
        '{SC_ECHO_IHL_ZERO,  1'b1, VERDICT_NONE},
        '{SC_ECHO_VERSION,   1'b1, VERDICT_NONE},
        '{SC_ECHO_PROTO,     1'b1, VERDICT_NONE},
        '{SC_ECHO_TYPE,      1'b1, VERDICT_NONE},
        '{SC_ECHO_CODE,      1'b1, VERDICT_NONE},
        '{SC_ECHO_BAD_ID,    1'b1, VERDICT_NONE},
        '{SC_ECHO_BAD_SEQ,   1'b1, VERDICT_NONE},
        '{SC_ECHO_BAD_DST,   1'b1, VERDICT_NONE},
        '{SC_OTHER_KIND,     1'b1, VERDICT_NONE}
    };

    // DUT ports; the inputs are known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_index = CFG_LOCAL_IP;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Bench state
    t_cfg        station_cfg;
    t_result     pending_verdicts[$];
    logic [7:0]  frame_bytes[];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;

    // Per-frame parse state of the classifier copy
    int unsigned rx_count;
    logic [15:0] rx_kind;
    logic [15:0] rx_arp_op;
    logic [47:0] rx_sha;
    logic [31:0] rx_spa;
    logic [31:0] rx_tpa;
    logic [3:0]  rx_hdr_words;
    bit          rx_ip_ok;
    bit          rx_echo_ok;

    arp_icmp_frame_classifier_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_rx();
        rx_count     = 0;
        rx_kind      = '0;
        rx_arp_op    = '0;
        rx_sha       = '0;
        rx_spa       = '0;
        rx_tpa       = '0;
        rx_hdr_words = '0;
        rx_ip_ok     = 1'b0;
        rx_echo_ok   = 1'b0;
    endfunction

    // Classifier copy: consume one byte, return 1 with the verdict on the last byte
    function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                         output t_result res);
        int unsigned idx;
        int unsigned icmp_ofs;
        res = '{VERDICT_NONE, '0, '0};
        idx = rx_count;
        if (idx == 12 || idx == 13) begin
            rx_kind = {rx_kind[7:0], b};
        end else if (rx_kind == KIND_ARP) begin
            if (idx == 20 || idx == 21)
                rx_arp_op = {rx_arp_op[7:0], b};
            else if (idx >= 22 && idx <= 27)
                rx_sha = {rx_sha[39:0], b};
            else if (idx >= 28 && idx <= 31)
                rx_spa = {rx_spa[23:0], b};
            else if (idx >= 38 && idx <= 41)
                rx_tpa = {rx_tpa[23:0], b};
        end else if (rx_kind == KIND_IPV4) begin
            icmp_ofs = 14 + 4 * int'(rx_hdr_words);
            if (idx == 14) begin
                rx_hdr_words = b[3:0];
                rx_ip_ok = (b[7:4] == 4'd4) && (b[3:0] >= 4'd5);
            end else if (idx == 23) begin
                rx_ip_ok = rx_ip_ok && (b == 8'd1);
            end else if (idx >= 26 && idx <= 29) begin
                rx_spa = {rx_spa[23:0], b};
            end else if (idx >= 30 && idx <= 33) begin
                rx_tpa = {rx_tpa[23:0], b};
            end else if (rx_hdr_words >= 4'd5 && idx >= icmp_ofs && idx < icmp_ofs + 8) begin
                // ICMP type, code, identifier and sequence checked byte by byte
                case (idx - icmp_ofs)
                    0: rx_echo_ok = (b == 8'd0);
                    1: rx_echo_ok = rx_echo_ok && (b == 8'd0);
                    4: rx_echo_ok = rx_echo_ok && (b == station_cfg.echo_identifier[15:8]);
                    5: rx_echo_ok = rx_echo_ok && (b == station_cfg.echo_identifier[7:0]);
                    6: rx_echo_ok = rx_echo_ok && (b == station_cfg.expected_sequence[15:8]);
                    7: rx_echo_ok = rx_echo_ok && (b == station_cfg.expected_sequence[7:0]);
                    default: ;
                endcase
            end
        end
        if (rx_count < FRAME_CAP)
            rx_count++;
        if (!last)
            return 1'b0;

        if (rx_kind == KIND_ARP && rx_count >= 42) begin
            if (rx_arp_op == 16'd1 && rx_tpa == station_cfg.local_ip)
                res.verdict = VERDICT_ARP_REQUEST;
            else if (rx_arp_op == 16'd2 && rx_spa == station_cfg.target_ip &&
                     rx_tpa == station_cfg.local_ip)
                res.verdict = VERDICT_ARP_REPLY;
            if (res.verdict != VERDICT_NONE) begin
                res.peer_mac = rx_sha;
                res.peer_ip  = rx_spa;
            end
        end else if (rx_kind == KIND_IPV4 && rx_ip_ok && rx_echo_ok &&
                     rx_spa == station_cfg.target_ip && rx_tpa == station_cfg.local_ip &&
                     rx_count >= 14 + 4 * int'(rx_hdr_words) + 40) begin
            res.verdict = VERDICT_ECHO_REPLY;
        end
        clear_rx();
        return 1'b1;
    endfunction

    // Big-endian field write, clipped to the frame length
    function automatic void put_be(input int unsigned pos, input logic [47:0] val,
                                   input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            if (pos + k < frame_bytes.size())
                frame_bytes[pos + k] = val[8 * (n - 1 - k) +: 8];
    endfunction

    function automatic void lay_out_frame(input t_frame f);
        int unsigned icmp_ofs;
        frame_bytes = new[f.len];
        foreach (frame_bytes[i])
            frame_bytes[i] = 8'($urandom);
        put_be(12, f.ether, 2);
        if (f.kind == FR_ARP) begin
            put_be(14, 16'h0001, 2);
            put_be(16, KIND_IPV4, 2);
            put_be(18, 16'h0604, 2);
            put_be(20, f.arp_op, 2);
            put_be(22, f.sha, 6);
            put_be(28, f.spa, 4);
            put_be(38, f.tpa, 4);
        end else if (f.kind == FR_IPV4) begin
            // a too-short header length still gets the ICMP header at the usual place
            icmp_ofs = 14 + 4 * ((f.ihl < 4'd5) ? 5 : int'(f.ihl));
            put_be(14, {f.version, f.ihl}, 1);
            put_be(23, f.proto, 1);
            put_be(26, f.spa, 4);
            put_be(30, f.tpa, 4);
            put_be(icmp_ofs, f.icmp_type, 1);
            put_be(icmp_ofs + 1, f.icmp_code, 1);
            put_be(icmp_ofs + 4, f.ident, 2);
            put_be(icmp_ofs + 6, f.seq, 2);
        end
    endfunction

    // Frame that should earn a verdict under the current configuration
    function automatic t_frame good_frame(input t_frame_kind kind);
        t_frame f;
        f.kind      = kind;
        f.sha       = {16'($urandom), 32'($urandom)};
        f.version   = 4'd4;
        f.proto     = 8'd1;
        f.icmp_type = 8'd0;
        f.icmp_code = 8'd0;
        f.ident     = station_cfg.echo_identifier;
        f.seq       = station_cfg.expected_sequence;
        f.tpa       = station_cfg.local_ip;
        if (kind == FR_ARP) begin
            f.ether  = KIND_ARP;
            f.arp_op = $urandom_range(0, 1) ? ARP_OP_REPLY : ARP_OP_REQUEST;
            f.spa    = (f.arp_op == ARP_OP_REPLY) ? station_cfg.target_ip : 32'($urandom);
            f.ihl    = 4'd5;
            f.len    = $urandom_range(42, 64);
        end else begin
            f.ether  = KIND_IPV4;
            f.arp_op = 16'($urandom);
            f.spa    = station_cfg.target_ip;
            f.ihl    = ($urandom_range(0, 99) < 80) ? 4'd5 : 4'($urandom_range(6, 15));
            f.len    = 14 + 4 * int'(f.ihl) + 40 + $urandom_range(0, 16);
        end
        return f;
    endfunction

    // Break one thing about a frame
    function automatic t_frame mangle(input t_frame f);
        case ($urandom_range(0, 11))
            0:  f.arp_op    = 16'($urandom);
            1:  f.spa       = f.spa ^ (32'd1 << $urandom_range(0, 31));
            2:  f.tpa       = f.tpa ^ (32'd1 << $urandom_range(0, 31));
            3:  f.ihl       = 4'($urandom_range(0, 4));
            4:  f.version   = 4'($urandom);
            5:  f.proto     = 8'($urandom);
            6:  f.icmp_type = 8'($urandom_range(1, 255));
            7:  f.icmp_code = 8'($urandom_range(1, 255));
            8:  f.ident     = f.ident ^ (16'd1 << $urandom_range(0, 15));
            9:  f.seq       = f.seq ^ (16'd1 << $urandom_range(0, 15));
            10: f.ether     = f.ether ^ (16'd1 << $urandom_range(0, 15));
            default: f.len  = $urandom_range(1, f.len - 1);
        endcase
        return f;
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            f = good_frame(FR_ARP);
        end else if (pick < 70) begin
            f = good_frame(FR_IPV4);
        end else if (pick < 90) begin
            f = mangle(good_frame($urandom_range(0, 1) ? FR_IPV4 : FR_ARP));
        end else begin
            f = good_frame(FR_ARP);
            f.kind  = FR_OTHER;
            f.ether = 16'($urandom);
            f.len   = $urandom_range(1, 80);
        end
        return f;
    endfunction

    function automatic t_frame directed_frame(input t_scenario sc);
        t_frame f;
        case (sc)
            SC_ONE_BYTE: begin
                f = good_frame(FR_ARP);
                f.len = 1;
            end
            SC_ARP_REQUEST, SC_ARP_MIN, SC_ARP_SHORT, SC_ARP_OTHER_TPA: begin
                f = good_frame(FR_ARP);
                f.arp_op = ARP_OP_REQUEST;
                f.spa = '1;
                if (sc == SC_ARP_REQUEST)   f.sha = '1;
                if (sc == SC_ARP_MIN)       begin f.sha = '0; f.spa = '0; f.len = 42; end
                if (sc == SC_ARP_SHORT)     f.len = 41;
                if (sc == SC_ARP_OTHER_TPA) f.tpa = ~station_cfg.local_ip;
            end
            SC_ARP_REPLY, SC_ARP_BAD_SENDER, SC_ARP_BAD_OP: begin
                f = good_frame(FR_ARP);
                f.arp_op = ARP_OP_REPLY;
                f.spa = station_cfg.target_ip;
                if (sc == SC_ARP_BAD_SENDER) f.spa = ~station_cfg.target_ip;
                if (sc == SC_ARP_BAD_OP)     f.arp_op = '1;
            end
            SC_OTHER_KIND: begin
                f = good_frame(FR_ARP);
                f.kind = FR_OTHER;
                f.ether = '1;
            end
            default: begin
                // IPv4 echo replies: the base case, one with options, and ones with one field off
                f = good_frame(FR_IPV4);
                f.ihl = 4'd5;
                f.len = 74;
                case (sc)
                    SC_ECHO_SHORT:    f.len = 73;
                    SC_ECHO_OPTIONS:  begin f.ihl = 4'd15; f.len = 114; end
                    SC_ECHO_IHL_LOW:  f.ihl = 4'd4;
                    SC_ECHO_IHL_ZERO: f.ihl = 4'd0;
                    SC_ECHO_VERSION:  f.version = '1;
                    SC_ECHO_PROTO:    f.proto = '1;
                    SC_ECHO_TYPE:     f.icmp_type = 8'd8;
                    SC_ECHO_CODE:     f.icmp_code = '1;
                    SC_ECHO_BAD_ID:   f.ident = f.ident ^ 16'h0100;
                    SC_ECHO_BAD_SEQ:  f.seq = f.seq ^ 16'h0001;
                    SC_ECHO_BAD_DST:  f.tpa = f.tpa ^ 32'h0000_0001;
                    default: ;
                endcase
            end
        endcase
        return f;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stream one frame in; the expectation is queued when its last byte is taken
    task automatic send_frame(input t_frame f, input bit typed, input t_verdict typed_verdict);
        t_result predicted;
        t_result want;
        int unsigned gap;
        int unsigned i;
        bit last;
        lay_out_frame(f);
        for (i = 0; i < frame_bytes.size(); i++) begin
            last = (i == frame_bytes.size() - 1);
            gap = pick_gap(src_gaps_on);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= frame_bytes[i];
            i_s_axis_tlast  <= last;
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
            if (classify_byte(frame_bytes[i], last, predicted)) begin
                want = predicted;
                if (typed) begin
                    want.verdict = typed_verdict;
                    if (typed_verdict == VERDICT_ARP_REQUEST ||
                        typed_verdict == VERDICT_ARP_REPLY) begin
                        want.peer_mac = f.sha;
                        want.peer_ip  = f.spa;
                    end else begin
                        want.peer_mac = '0;
                        want.peer_ip  = '0;
                    end
                end
                pending_verdicts.push_back(want);
            end
        end
    endtask

    // Let the block drain; it may still hold a byte after the last verdict
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write all four registers back to back; 16-bit ones get junk in the upper half
    task automatic load_config(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOCAL_IP;
        i_cfg_wdata <= c.local_ip;
        @(posedge i_clk);
        i_cfg_index <= CFG_TARGET_IP;
        i_cfg_wdata <= c.target_ip;
        @(posedge i_clk);
        i_cfg_index <= CFG_EXPECTED_SEQ;
        i_cfg_wdata <= {16'($urandom), c.expected_sequence};
        @(posedge i_clk);
        i_cfg_index <= CFG_ECHO_ID;
        i_cfg_wdata <= {16'($urandom), c.echo_identifier};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        station_cfg = c;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: compare each taken request, then decide next cycle's tready
    always @(posedge i_clk) begin : result_sink
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict with no frame pending: tdata 0x%0h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("verdict", want.verdict, o_m_axis_tdata[1:0]);
                check_field("peer_mac", want.peer_mac, o_m_axis_tdata[49:2]);
                check_field("peer_ip", want.peer_ip, o_m_axis_tdata[81:50]);
                check_field("pad", '0, o_m_axis_tdata[M_TDATA_W-1:82]);
            end
        end
        if (stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
            i_m_axis_tready <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 60);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        t_frame      f;
        t_cfg        c;
        int unsigned phase;
        int unsigned random_frames;
        phase = 0;
        random_frames = 0;
        station_cfg = '{LOCAL_IP_RESET, TARGET_IP_RESET, EXP_SEQ_RESET, ECHO_ID_RESET};
        clear_rx();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under reset configuration
        foreach (directed_rows[i])
            send_frame(directed_frame(directed_rows[i].scenario), directed_rows[i].typed,
                       directed_rows[i].verdict);

        // Random phases, each with a fresh configuration and idling mix
        while (random_frames < 8) begin
            settle();
            case (phase % 5)
                0: c = '{'0, '0, '0, '0};
                1: c = '{'1, '1, '1, '1};
                2: c = '{LOCAL_IP_RESET, TARGET_IP_RESET, EXP_SEQ_RESET, ECHO_ID_RESET};
                default: c = '{32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom)};
            endcase
            load_config(c);
            src_gaps_on    = (phase % 3 != 1);
            sink_stalls_on = (phase % 4 != 2);
            repeat (2) begin
                f = random_frame();
                send_frame(f, 1'b0, VERDICT_NONE);
                random_frames++;
            end
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
